FILE: hdl/rtpt_pkg.sv
package rtpt_pkg;

  localparam int NODE_COUNT = 64;
  localparam int ENTRIES_PER_NODE = 512;
  localparam int LEVELS = 4;
  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int IDX_W = $clog2(ENTRIES_PER_NODE);
  localparam int ADDR_W = NODE_W + IDX_W;
  localparam int DEPTH = NODE_COUNT * ENTRIES_PER_NODE;
  localparam int LVL_W = 2;
  localparam int VA_W = 48;
  localparam int PA_W = 64;
  localparam int ENTRY_W = PA_W + 1;
  localparam logic [PA_W-1:0] ABSENT = '1;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_MAPPED   = 3'd3,
    ST_NOFREE   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    A_WALK  = 2'd0,
    A_ALLOC = 2'd1,
    A_CHILD = 2'd2
  } addr_sel_e;

  typedef enum logic [1:0] {
    W_ABSENT = 2'd0,
    W_PA     = 2'd1,
    W_LINK   = 2'd2
  } wr_sel_e;

  typedef struct packed {
    logic      start;
    addr_sel_e addr_sel;
    logic      we;
    wr_sel_e   wsel;
    logic      descend;
    logic      link_descend;
    logic      scan_clr;
    logic      scan_inc;
    logic      alloc_init;
    logic      alloc_inc;
    logic      child_load;
    logic      child_free;
    logic      cache_set;
    logic      cache_clr;
    logic      res_load;
    status_e   res_code;
    logic      res_hit;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    kind_e in_kind;
    kind_e kind;
    logic  absent;
    logic  term;
    logic  link_bad;
    logic  link_zero;
    logic  lvl_zero;
    logic  steps_zero;
    logic  scan_last;
    logic  alloc_used;
    logic  alloc_last;
    logic  out_free;
  } sts_t;

endpackage

FILE: hdl/radix_page_table_engine.sv
// Four-level radix page table over a pool of 64 nodes of 512 entries, kept in
// one single-port entry memory with registered read. One transaction at a
// time: a lookup or remove has a read state and an evaluation state per
// level read (one memory read and one evaluation each) between an accept
// state and a respond state, and a remove that hits adds a write state;
// fewer levels are read when the walk cache lets a lookup start deeper. An
// insert walks the levels the same way, plus for each node it allocates a
// scan of the used map (one node per cycle, up to 63) and a clearing sweep
// of its 512 entries; a 2M insert over a level-0 node adds an emptiness check
// that reads and evaluates each of its 512 entries. After reset the root node
// is cleared in a pass over its 512 entries before the first input transaction
// is taken. A finished result sits in an output register, so the next input transaction is taken while it waits.
module radix_page_table_engine import rtpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] va, [111:48] pa, [112] page_is_2m, rest zero
  input  logic [119:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] status, [66:3] result_pa, [67] result_is_2m, rest zero
  output logic [71:0]  m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;
  logic [2:0]      out_status;
  logic [PA_W-1:0] out_pa;
  logic            out_2m;

  rtpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rtpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (s_axis_tuser),
    .in_va_i     (s_axis_tdata[47:0]),
    .in_pa_i     (s_axis_tdata[111:48]),
    .in_big_i    (s_axis_tdata[112]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_status_o(out_status),
    .out_pa_o    (out_pa),
    .out_is_2m_o (out_2m)
  );

  // pack result fields
  assign m_axis_tdata = {4'b0, out_2m, out_pa, out_status};

endmodule

FILE: hdl/rtpt_ram.sv
module rtpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rtpt_ctrl.sv
module rtpt_ctrl import rtpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_INIT = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_RD   = 12'b000000000100,
    S_EVAL = 12'b000000001000,
    S_SCAN = 12'b000000010000,
    S_CLR  = 12'b000000100000,
    S_LINK = 12'b000001000000,
    S_ERD  = 12'b000010000000,
    S_EEV  = 12'b000100000000,
    S_WPA  = 12'b001000000000,
    S_WRM  = 12'b010000000000,
    S_RESP = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.addr_sel = A_WALK;
    cmd_o.wsel = W_ABSENT;
    cmd_o.res_code = ST_OK;
    unique case (state_q)
      S_INIT: begin
        cmd_o.addr_sel = A_ALLOC;
        cmd_o.we = 1'b1;
        cmd_o.scan_inc = 1'b1;
        if (sts_i.scan_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (sts_i.in_kind == KIND_NONE) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = ST_NOTFOUND;
            state_d = S_RESP;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: state_d = S_EVAL;
      S_EVAL: begin
        if (sts_i.kind == KIND_INSERT) begin
          if (!sts_i.steps_zero) begin
            if (sts_i.absent) begin
              // clearing sweep of the new node starts at entry zero
              cmd_o.alloc_init = 1'b1;
              cmd_o.scan_clr = 1'b1;
              state_d = S_SCAN;
            end else if (sts_i.term || sts_i.link_bad) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = ST_OVERLAP;
              state_d = S_RESP;
            end else begin
              cmd_o.descend = 1'b1;
              state_d = S_RD;
            end
          end else begin
            cmd_o.cache_clr = 1'b1;
            if (sts_i.absent) begin
              state_d = S_WPA;
            end else if (!sts_i.lvl_zero && !sts_i.term) begin
              if (sts_i.link_bad || sts_i.link_zero) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_code = ST_OVERLAP;
                state_d = S_RESP;
              end else begin
                cmd_o.child_load = 1'b1;
                cmd_o.scan_clr = 1'b1;
                state_d = S_ERD;
              end
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = ST_MAPPED;
              state_d = S_RESP;
            end
          end
        end else begin
          // lookup and remove walk the same way
          if (sts_i.absent) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = ST_NOTFOUND;
            state_d = S_RESP;
          end else if (sts_i.term) begin
            if (sts_i.kind == KIND_REMOVE) begin
              state_d = S_WRM;
            end else begin
              cmd_o.cache_set = 1'b1;
              cmd_o.res_load = 1'b1;
              cmd_o.res_hit = 1'b1;
              cmd_o.res_code = ST_OK;
              state_d = S_RESP;
            end
          end else if (sts_i.link_bad || sts_i.lvl_zero) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = ST_NOTFOUND;
            state_d = S_RESP;
          end else begin
            cmd_o.descend = 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_SCAN: begin
        if (!sts_i.alloc_used) begin
          state_d = S_CLR;
        end else if (sts_i.alloc_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = ST_NOFREE;
          state_d = S_RESP;
        end else begin
          cmd_o.alloc_inc = 1'b1;
        end
      end
      S_CLR: begin
        cmd_o.addr_sel = A_ALLOC;
        cmd_o.we = 1'b1;
        cmd_o.scan_inc = 1'b1;
        if (sts_i.scan_last) state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.we = 1'b1;
        cmd_o.wsel = W_LINK;
        cmd_o.link_descend = 1'b1;
        state_d = S_RD;
      end
      S_ERD: begin
        cmd_o.addr_sel = A_CHILD;
        state_d = S_EEV;
      end
      S_EEV: begin
        if (!sts_i.absent) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = ST_OVERLAP;
          state_d = S_RESP;
        end else if (sts_i.scan_last) begin
          cmd_o.child_free = 1'b1;
          state_d = S_WPA;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = S_ERD;
        end
      end
      S_WPA: begin
        cmd_o.we = 1'b1;
        cmd_o.wsel = W_PA;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = ST_OK;
        state_d = S_RESP;
      end
      S_WRM: begin
        cmd_o.we = 1'b1;
        cmd_o.wsel = W_ABSENT;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = ST_OK;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/rtpt_dp.sv
module rtpt_dp import rtpt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic [1:0]      in_kind_i,
  input  logic [VA_W-1:0] in_va_i,
  input  logic [PA_W-1:0] in_pa_i,
  input  logic            in_big_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [2:0]      out_status_o,
  output logic [PA_W-1:0] out_pa_o,
  output logic            out_is_2m_o
);

  // latched operation
  kind_e             kind_q;
  logic [VA_W-1:0]   va_q;
  logic [PA_W-1:0]   pa_q;
  // walk position
  logic [NODE_W-1:0] node_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [LVL_W-1:0]  steps_q;
  // sweeps and allocation
  logic [IDX_W-1:0]  scan_q;
  logic [NODE_W-1:0] alloc_q;
  logic [NODE_W-1:0] child_q;
  logic [NODE_COUNT-1:0] used_q;
  // walk cache
  logic              cvalid_q;
  logic [LVL_W-1:0]  clvl_q;
  logic [VA_W-1:0]   cva_q;
  logic [NODE_W-1:0] cnode_q;
  // pending and output results
  status_e           res_code_q;
  logic [PA_W-1:0]   res_pa_q;
  logic              res_2m_q;
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [PA_W-1:0]   out_pa_q;
  logic              out_2m_q;

  logic [ADDR_W-1:0]  addr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [PA_W-1:0]    rd_value;
  logic               rd_term;
  logic [IDX_W-1:0]   walk_idx;
  logic               cache_hit;
  logic [VA_W-1:0]    va_diff;
  logic               out_free;

  assign rd_value = rdata[PA_W-1:0];
  assign rd_term  = rdata[PA_W];

  // index bits of the current level
  always_comb begin
    case (lvl_q)
      2'd0:    walk_idx = va_q[12 +: IDX_W];
      2'd1:    walk_idx = va_q[21 +: IDX_W];
      2'd2:    walk_idx = va_q[30 +: IDX_W];
      default: walk_idx = va_q[39 +: IDX_W];
    endcase
  end

  // walk cache match against the incoming address
  assign va_diff = cva_q ^ in_va_i;
  always_comb begin
    case (clvl_q)
      2'd0:    cache_hit = (va_diff[VA_W-1:12] == '0);
      2'd1:    cache_hit = (va_diff[VA_W-1:21] == '0);
      2'd2:    cache_hit = (va_diff[VA_W-1:30] == '0);
      default: cache_hit = (va_diff[VA_W-1:39] == '0);
    endcase
    cache_hit = cache_hit && cvalid_q && (int'(clvl_q) < LEVELS);
  end

  // entry address and write data
  always_comb begin
    case (cmd_i.addr_sel)
      A_ALLOC: addr = {alloc_q, scan_q};
      A_CHILD: addr = {child_q, scan_q};
      default: addr = {node_q, walk_idx};
    endcase
    case (cmd_i.wsel)
      W_PA:    wdata = {1'b1, pa_q};
      W_LINK:  wdata = {1'b0, {(PA_W-NODE_W){1'b0}}, alloc_q};
      default: wdata = {1'b0, ABSENT};
    endcase
  end

  rtpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // status toward the controller
  always_comb begin
    sts_o.in_kind    = kind_e'(in_kind_i);
    sts_o.kind       = kind_q;
    sts_o.absent     = (rd_value == ABSENT);
    sts_o.term       = rd_term;
    sts_o.link_bad   = (rd_value >= PA_W'(NODE_COUNT));
    sts_o.link_zero  = (rd_value == '0);
    sts_o.lvl_zero   = (lvl_q == '0);
    sts_o.steps_zero = (steps_q == '0);
    sts_o.scan_last  = (scan_q == IDX_W'(ENTRIES_PER_NODE - 1));
    sts_o.alloc_used = used_q[alloc_q];
    sts_o.alloc_last = (alloc_q == NODE_W'(NODE_COUNT - 1));
    sts_o.out_free   = out_free;
  end

  // operation and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q <= kind_e'(in_kind_i);
      va_q   <= in_va_i;
      pa_q   <= in_pa_i;
      if (kind_e'(in_kind_i) == KIND_LOOKUP && cache_hit) begin
        node_q <= cnode_q;
        lvl_q  <= clvl_q;
      end else begin
        node_q <= '0;
        lvl_q  <= LVL_W'(LEVELS - 1);
      end
      steps_q <= in_big_i ? LVL_W'(LEVELS - 2) : LVL_W'(LEVELS - 1);
    end else if (cmd_i.descend) begin
      node_q  <= rd_value[NODE_W-1:0];
      lvl_q   <= lvl_q - 1'b1;
      steps_q <= steps_q - 1'b1;
    end else if (cmd_i.link_descend) begin
      node_q  <= alloc_q;
      lvl_q   <= lvl_q - 1'b1;
      steps_q <= steps_q - 1'b1;
    end
    if (cmd_i.child_load) child_q <= rd_value[NODE_W-1:0];
    if (cmd_i.res_load) begin
      res_code_q <= cmd_i.res_code;
      res_pa_q   <= cmd_i.res_hit ? rd_value : '0;
      res_2m_q   <= cmd_i.res_hit && (lvl_q == LVL_W'(1));
    end
    if (cmd_i.emit) begin
      out_status_q <= res_code_q;
      out_pa_q     <= res_pa_q;
      out_2m_q     <= res_2m_q;
    end
    if (cmd_i.cache_set) begin
      cva_q   <= va_q;
      clvl_q  <= lvl_q;
      cnode_q <= node_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      alloc_q     <= '0;
      used_q      <= NODE_COUNT'(1);
      cvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.alloc_init) begin
        alloc_q <= NODE_W'(1);
      end else if (cmd_i.alloc_inc) begin
        alloc_q <= alloc_q + 1'b1;
      end
      if (cmd_i.link_descend) used_q[alloc_q] <= 1'b1;
      if (cmd_i.child_free) used_q[child_q] <= 1'b0;
      if (cmd_i.cache_set) begin
        cvalid_q <= 1'b1;
      end else if (cmd_i.cache_clr) begin
        cvalid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_pa_o     = out_pa_q;
  assign out_is_2m_o  = out_2m_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rtpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 480;

  typedef struct {
    kind_e       kind;
    logic [47:0] va;
    logic [63:0] pa;
    logic        big;
    logic        typed;
    status_e     est;
    logic [63:0] epa;
    logic        eb;
  } op_t;

  typedef struct {
    status_e     st;
    logic [63:0] pa;
    logic        big;
  } answer_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // [47:0] va, [111:48] pa, [112] page_is_2m, rest zero
  logic [119:0] s_axis_tdata;
  // [1:0] kind
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [2:0] status, [66:3] result_pa, [67] result_is_2m, rest zero
  logic [71:0]  m_axis_tdata;

  radix_page_table_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow page table
  logic [63:0] pt_value [DEPTH];
  logic        pt_leaf  [DEPTH];
  logic        node_busy [NODE_COUNT];
  logic        wc_valid;
  int          wc_level;
  logic [47:0] wc_va;
  int          wc_node;

  answer_t     pending_answers[$];
  int          errors = 0;
  int          idle_cycles = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int level_idx(int lvl, logic [47:0] va);
    return int'((va >> (12 + 9 * lvl)) & 48'h1ff);
  endfunction

  function automatic logic [47:0] level_mask(int lvl);
    return (48'hffff_ffff_ffff >> (12 + 9 * lvl)) << (12 + 9 * lvl);
  endfunction

  function automatic void wipe_node(int n);
    for (int i = 0; i < ENTRIES_PER_NODE; i++) begin
      pt_value[n * ENTRIES_PER_NODE + i] = ABSENT;
      pt_leaf[n * ENTRIES_PER_NODE + i] = 1'b0;
    end
  endfunction

  function automatic logic node_vacant(int n);
    for (int i = 0; i < ENTRIES_PER_NODE; i++)
      if (pt_value[n * ENTRIES_PER_NODE + i] != ABSENT) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int grab_node();
    for (int i = 1; i < NODE_COUNT; i++)
      if (!node_busy[i]) return i;
    return -1;
  endfunction

  // walk for a translation, starting deeper on a walk cache hit
  function automatic status_e translate(logic [47:0] va, output logic [63:0] pa,
                                        output logic big);
    logic [63:0] node = 0;
    int lvl = LEVELS;
    int e;
    pa = '0;
    big = 1'b0;
    if (wc_valid && wc_level < LEVELS && ((wc_va ^ va) & level_mask(wc_level)) == 0) begin
      node = 64'(wc_node);
      lvl = wc_level + 1;
    end
    while (lvl > 0) begin
      lvl--;
      if (node >= NODE_COUNT) return ST_NOTFOUND;
      e = int'(node) * ENTRIES_PER_NODE + level_idx(lvl, va);
      if (pt_value[e] == ABSENT) return ST_NOTFOUND;
      if (pt_leaf[e]) begin
        wc_valid = 1'b1;
        wc_level = lvl;
        wc_va = va;
        wc_node = int'(node);
        pa = pt_value[e];
        big = (lvl == 1);
        return ST_OK;
      end
      node = pt_value[e];
    end
    return ST_NOTFOUND;
  endfunction

  // map a page, allocating missing nodes on the way down
  function automatic status_e map_page(logic [47:0] va, logic [63:0] pa, logic big);
    logic [63:0] node = 0;
    logic [63:0] child;
    int lvl = LEVELS;
    int steps = big ? LEVELS - 2 : LEVELS - 1;
    int e;
    int n;
    while (steps > 0) begin
      lvl--;
      steps--;
      e = int'(node) * ENTRIES_PER_NODE + level_idx(lvl, va);
      if (pt_value[e] == ABSENT) begin
        n = grab_node();
        if (n < 0) return ST_NOFREE;
        wipe_node(n);
        node_busy[n] = 1'b1;
        pt_value[e] = 64'(n);
        pt_leaf[e] = 1'b0;
      end
      if (pt_leaf[e]) return ST_OVERLAP;
      node = pt_value[e];
      if (node >= NODE_COUNT) return ST_OVERLAP;
    end
    e = int'(node) * ENTRIES_PER_NODE + level_idx(lvl - 1, va);
    wc_valid = 1'b0;
    if (pt_value[e] != ABSENT) begin
      if (lvl >= 2 && !pt_leaf[e]) begin
        child = pt_value[e];
        if (child >= NODE_COUNT || child == 0 || !node_vacant(int'(child)))
          return ST_OVERLAP;
        node_busy[int'(child)] = 1'b0;
      end else begin
        return ST_MAPPED;
      end
    end
    pt_value[e] = pa;
    pt_leaf[e] = 1'b1;
    return ST_OK;
  endfunction

  // clear the terminal entry, nodes stay allocated
  function automatic status_e unmap_page(logic [47:0] va);
    logic [63:0] node = 0;
    int lvl = LEVELS;
    int e;
    while (lvl > 0) begin
      lvl--;
      if (node >= NODE_COUNT) return ST_NOTFOUND;
      e = int'(node) * ENTRIES_PER_NODE + level_idx(lvl, va);
      if (pt_value[e] == ABSENT) return ST_NOTFOUND;
      if (pt_leaf[e]) begin
        pt_value[e] = ABSENT;
        pt_leaf[e] = 1'b0;
        return ST_OK;
      end
      node = pt_value[e];
    end
    return ST_NOTFOUND;
  endfunction

  function automatic answer_t predict_answer(op_t op);
    answer_t a;
    a.pa = '0;
    a.big = 1'b0;
    case (op.kind)
      KIND_LOOKUP: a.st = translate(op.va, a.pa, a.big);
      KIND_INSERT: a.st = map_page(op.va, op.pa, op.big);
      KIND_REMOVE: a.st = unmap_page(op.va);
      default:     a.st = ST_NOTFOUND;
    endcase
    if (a.st != ST_OK) begin
      a.pa = '0;
      a.big = 1'b0;
    end
    return a;
  endfunction

  function automatic op_t mk_op(kind_e kind, logic [47:0] va, logic [63:0] pa, logic big,
                                logic typed = 1'b0, status_e est = ST_OK,
                                logic [63:0] epa = '0, logic eb = 1'b0);
    op_t o;
    o.kind = kind; o.va = va; o.pa = pa; o.big = big;
    o.typed = typed; o.est = est; o.epa = epa; o.eb = eb;
    return o;
  endfunction

  // random item, mostly inside a few shared subtrees so walks go deep
  function automatic op_t random_op();
    op_t o;
    int r = $urandom_range(0, 99);
    logic [8:0] i3, i2, i1, i0;
    o.typed = 1'b0;
    o.kind = r < 40 ? KIND_LOOKUP : r < 75 ? KIND_INSERT : r < 94 ? KIND_REMOVE : KIND_NONE;
    i3 = ($urandom_range(0, 7) == 0) ? 9'h1ff : 9'($urandom_range(0, 3));
    i2 = 9'($urandom_range(0, 3));
    i1 = 9'($urandom_range(0, 7));
    i0 = 9'($urandom_range(0, 15));
    o.va = {i3, i2, i1, i0, 12'($urandom)};
    if ($urandom_range(0, 9) == 0) o.va = {16'($urandom), 32'($urandom)};
    o.pa = {32'($urandom), 32'($urandom)};
    if ($urandom_range(0, 49) == 0) o.pa = ABSENT;
    o.big = ($urandom_range(0, 9) < 3);
    return o;
  endfunction

  // send one item and record its expected answer on acceptance
  task automatic send_op(op_t op, logic no_gap);
    int gap;
    answer_t a;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op.kind;
    s_axis_tdata <= {7'b0, op.big, op.pa, op.va};
    do @(posedge clk_i); while (!s_axis_tready);
    a = predict_answer(op);
    if (op.typed) begin
      a.st = op.est;
      a.pa = op.epa;
      a.big = op.eb;
    end
    pending_answers.push_back(a);
  endtask

  // stimulus
  initial begin
    op_t ops[$];
    for (int n = 0; n < NODE_COUNT; n++) begin
      wipe_node(n);
      node_busy[n] = 1'b0;
    end
    node_busy[0] = 1'b1;
    wc_valid = 1'b0;
    wc_level = 0;
    wc_va = '0;
    wc_node = 0;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_LOOKUP;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: empty table, all kinds, overlap rules, extremes
    ops.push_back(mk_op(KIND_LOOKUP, 48'h0, '0, 1'b0, 1'b1, ST_NOTFOUND));
    ops.push_back(mk_op(KIND_REMOVE, 48'h0, '0, 1'b0, 1'b1, ST_NOTFOUND));
    ops.push_back(mk_op(KIND_NONE, 48'hffff_ffff_ffff, ABSENT, 1'b1, 1'b1, ST_NOTFOUND));
    ops.push_back(mk_op(KIND_INSERT, 48'h1000, 64'h0, 1'b0, 1'b1, ST_OK));
    ops.push_back(mk_op(KIND_LOOKUP, 48'h1fff, '0, 1'b0));
    ops.push_back(mk_op(KIND_INSERT, 48'h1abc, 64'h55, 1'b0, 1'b1, ST_MAPPED));
    ops.push_back(mk_op(KIND_INSERT, 48'h0, 64'h77, 1'b1, 1'b1, ST_OVERLAP));
    ops.push_back(mk_op(KIND_REMOVE, 48'h1000, '0, 1'b0, 1'b1, ST_OK));
    ops.push_back(mk_op(KIND_LOOKUP, 48'h1000, '0, 1'b0, 1'b1, ST_NOTFOUND));
    ops.push_back(mk_op(KIND_INSERT, 48'h0, 64'h8000_0000_0020_0000, 1'b1));
    ops.push_back(mk_op(KIND_LOOKUP, 48'h1f_ffff, '0, 1'b0));
    ops.push_back(mk_op(KIND_LOOKUP, 48'h10_0000, '0, 1'b0));
    ops.push_back(mk_op(KIND_INSERT, 48'h5000, 64'h1, 1'b0, 1'b1, ST_OVERLAP));
    ops.push_back(mk_op(KIND_INSERT, 48'h0, 64'h2, 1'b1, 1'b1, ST_MAPPED));
    ops.push_back(mk_op(KIND_INSERT, 48'hffff_ffff_f000, 64'hffff_ffff_ffff_fffe, 1'b0));
    ops.push_back(mk_op(KIND_LOOKUP, 48'hffff_ffff_ffff, '0, 1'b0));
    ops.push_back(mk_op(KIND_INSERT, 48'hffff_ffe0_0000, 64'h3, 1'b1));
    ops.push_back(mk_op(KIND_INSERT, 48'h2000_0000, ABSENT, 1'b0));
    ops.push_back(mk_op(KIND_LOOKUP, 48'h2000_0000, '0, 1'b0));
    ops.push_back(mk_op(KIND_REMOVE, 48'h1f_f000, '0, 1'b0));
    ops.push_back(mk_op(KIND_LOOKUP, 48'h0, '0, 1'b0, 1'b1, ST_NOTFOUND));
    ops.push_back(mk_op(KIND_LOOKUP, 48'hffff_ffff_f123, '0, 1'b0));
    foreach (ops[i]) send_op(ops[i], 1'b0);

    // random part, with a stretch of back-to-back items
    for (int i = 0; i < RANDOM_ITEMS; i++) send_op(random_op(), (i >= 250 && i < 310));
    s_axis_tvalid <= 1'b0;

    wait (pending_answers.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side ready, with one long hold-off and one stall-free stretch
  initial begin
    int stall;
    int taken = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken == 40) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = (taken >= 260 && taken < 320) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    answer_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[2:0] !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[66:3] !== want.pa) begin
          $display("%0t: result_pa expected %h actual %h", $time, want.pa,
                   m_axis_tdata[66:3]);
          errors++;
        end
        if (m_axis_tdata[67] !== want.big) begin
          $display("%0t: result_is_2m expected %b actual %b", $time, want.big,
                   m_axis_tdata[67]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress, %0d results outstanding", $time, pending_answers.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
